// File: rtl/arc_pkg.sv
// ----------------------------------------------------------------------------
// arc_pkg
// Shared types and constants of the alphabet radix converter: field widths,
// register indexes, status codes, controller states and the command/status
// structs between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package arc_pkg;

    localparam int SYM_W       = 8;
    localparam int DIGIT_W     = 4;
    localparam int RADIX_W     = 5;
    localparam int MAX_RADIX   = 16;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 64;
    localparam int ALPHA_W     = SYM_W * MAX_RADIX;

    localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);
    localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);
    localparam logic [RADIX_W-1:0] RADIX_MAX   = RADIX_W'(MAX_RADIX);

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_RADIX = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_DEST_RADIX   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_SRC_ALPHA_LO = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SRC_ALPHA_HI = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_DST_ALPHA_LO = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_DST_ALPHA_HI = 3'd5;

    typedef enum logic [1:0] {
        STATUS_OK         = 2'd0,
        STATUS_BAD_SYMBOL = 2'd1,
        STATUS_OVERFLOW   = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_READ,
        ST_LOAD
    } t_state;

    typedef struct packed {
        logic accept;     // take one source word into the accumulator
        logic start_div;  // load the dividend, clear the digit count
        logic div_step;   // one 4-bit long-division step
        logic rd_issue;   // read the next stored digit, count down
        logic load_char;  // put the read digit's symbol in the output register
        logic load_err;   // put the error word in the output register
        logic clear;      // drop the current number
    } t_cmd;

    typedef struct packed {
        logic err_set;      // an error is held for this number
        logic div_last;     // this division step finishes a digit
        logic digit_final;  // the digit being finished is the last one
        logic out_free;     // output register can take a word this cycle
        logic cnt_zero;     // no more stored digits
    } t_stat;

    function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] r);
        logic [RADIX_W-1:0] res;
        res = r;
        if (r < RADIX_MIN) begin
            res = RADIX_MIN;
        end else if (r > RADIX_MAX) begin
            res = RADIX_MAX;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// File: rtl/arc_ram.sv
// ----------------------------------------------------------------------------
// arc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module arc_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: rtl/arc_ctrl.sv
// ----------------------------------------------------------------------------
// arc_ctrl
// Controller of the alphabet radix converter: accepts source words, runs the
// repeated division and then reads the stored digits back, most significant
// first, into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module arc_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    input  wire logic           i_in_last,
    output logic                o_in_ready,
    input  wire arc_pkg::t_stat i_stat,
    output arc_pkg::t_cmd       o_cmd
);

    import arc_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_in_last) begin
                        n_state = ST_CHECK;
                    end
                end
            end
            ST_CHECK: begin
                if (i_stat.err_set) begin
                    // hold until the output register frees up
                    if (i_stat.out_free) begin
                        o_cmd.load_err = 1'b1;
                        o_cmd.clear    = 1'b1;
                        n_state        = ST_IDLE;
                    end
                end else begin
                    o_cmd.start_div = 1'b1;
                    n_state         = ST_DIV;
                end
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_last && i_stat.digit_final) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                if (i_stat.out_free) begin
                    o_cmd.rd_issue = 1'b1;
                    n_state        = ST_LOAD;
                end
            end
            ST_LOAD: begin
                o_cmd.load_char = 1'b1;
                if (i_stat.cnt_zero) begin
                    o_cmd.clear = 1'b1;
                    n_state     = ST_IDLE;
                end else begin
                    n_state = ST_READ;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/arc_dpath.sv
// ----------------------------------------------------------------------------
// arc_dpath
// Datapath of the alphabet radix converter: configuration registers, symbol
// lookup and accumulator, a 4-bit-per-cycle long divider, the digit RAM and
// the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module arc_dpath #(
    parameter int VALUE_BITS = 32
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [arc_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  wire logic [arc_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    input  wire logic [arc_pkg::SYM_W-1:0]        i_in_symbol,
    input  wire arc_pkg::t_cmd                    i_cmd,
    output arc_pkg::t_stat                        o_stat,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_ready,
    output logic      [arc_pkg::SYM_W-1:0]        o_out_symbol,
    output logic                                  o_out_last,
    output logic      [1:0]                       o_out_status
);

    import arc_pkg::*;

    localparam int DEPTH  = VALUE_BITS;
    localparam int AW     = $clog2(DEPTH);
    localparam int CW     = $clog2(DEPTH + 1);
    localparam int DIV_W  = ((VALUE_BITS + 3) / 4) * 4;
    localparam int NSTEPS = DIV_W / 4;
    localparam int NW     = (NSTEPS > 1) ? $clog2(NSTEPS) : 1;
    localparam int PW     = VALUE_BITS + RADIX_W;

    // Configuration
    logic [RADIX_W-1:0] r_src_radix;
    logic [RADIX_W-1:0] r_dst_radix;
    logic [ALPHA_W-1:0] r_src_alpha;
    logic [ALPHA_W-1:0] r_dst_alpha;

    // Number state
    logic [VALUE_BITS-1:0] r_accum;
    t_status               r_err;
    logic [CW-1:0]         r_cnt;
    logic [DIV_W-1:0]      r_work;
    logic [RADIX_W-1:0]    r_rem;
    logic [NW-1:0]         r_nib;

    // Output register
    logic               r_out_valid;
    logic [SYM_W-1:0]   r_out_symbol;
    logic               r_out_last;
    t_status            r_out_status;

    logic [RADIX_W-1:0] w_srad;
    logic [RADIX_W-1:0] w_drad;
    logic               w_found;
    logic [DIGIT_W-1:0] w_digit;
    logic [PW-1:0]      w_next;
    logic               w_ovf;
    logic [DIV_W-1:0]   n_work;
    logic [RADIX_W-1:0] n_rem;
    logic               w_div_last;
    logic [CW-1:0]      w_cnt_dec;
    logic [DIGIT_W-1:0] w_rdata;
    logic               w_out_free;

    assign w_srad = clamp_radix(r_src_radix);
    assign w_drad = clamp_radix(r_dst_radix);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_radix <= RADIX_RESET;
            r_dst_radix <= RADIX_RESET;
            r_src_alpha <= '0;
            r_dst_alpha <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_SOURCE_RADIX: r_src_radix <= i_cfg_wdata[RADIX_W-1:0];
                REG_DEST_RADIX:   r_dst_radix <= i_cfg_wdata[RADIX_W-1:0];
                REG_SRC_ALPHA_LO: r_src_alpha[CFG_DATA_W-1:0] <= i_cfg_wdata;
                REG_SRC_ALPHA_HI: r_src_alpha[ALPHA_W-1:CFG_DATA_W] <= i_cfg_wdata;
                REG_DST_ALPHA_LO: r_dst_alpha[CFG_DATA_W-1:0] <= i_cfg_wdata;
                REG_DST_ALPHA_HI: r_dst_alpha[ALPHA_W-1:CFG_DATA_W] <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Lowest matching position wins: scan from the top, later hits override.
    always_comb begin
        w_found = 1'b0;
        w_digit = '0;
        for (int p = MAX_RADIX - 1; p >= 0; p--) begin
            if ((RADIX_W'(p) < w_srad) && (r_src_alpha[p*SYM_W +: SYM_W] == i_in_symbol)) begin
                w_found = 1'b1;
                w_digit = DIGIT_W'(p);
            end
        end
    end

    assign w_next = PW'(r_accum) * PW'(w_srad) + PW'(w_digit);
    assign w_ovf  = |w_next[PW-1:VALUE_BITS];

    // Four restoring-division bits per cycle; remainder stays below the radix.
    always_comb begin
        logic [RADIX_W:0] t;
        n_work = r_work;
        n_rem  = r_rem;
        for (int k = 0; k < 4; k++) begin
            t      = {n_rem, n_work[DIV_W-1]};
            n_work = {n_work[DIV_W-2:0], 1'b0};
            if (t >= {1'b0, w_drad}) begin
                t         = t - {1'b0, w_drad};
                n_work[0] = 1'b1;
            end
            n_rem = t[RADIX_W-1:0];
        end
    end

    assign w_div_last = (r_nib == NW'(NSTEPS - 1));
    assign w_cnt_dec  = r_cnt - 1'b1;
    assign w_out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accum <= '0;
            r_err   <= STATUS_OK;
            r_cnt   <= '0;
            r_nib   <= '0;
        end else begin
            if (i_cmd.clear) begin
                r_accum <= '0;
                r_err   <= STATUS_OK;
                r_cnt   <= '0;
            end else if (i_cmd.accept && (r_err == STATUS_OK)) begin
                if (!w_found) begin
                    r_err <= STATUS_BAD_SYMBOL;
                end else if (w_ovf) begin
                    r_err <= STATUS_OVERFLOW;
                end else begin
                    r_accum <= w_next[VALUE_BITS-1:0];
                end
            end
            if (i_cmd.start_div) begin
                r_cnt <= '0;
                r_nib <= '0;
            end else if (i_cmd.div_step) begin
                r_nib <= w_div_last ? '0 : r_nib + 1'b1;
                if (w_div_last) begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end else if (i_cmd.rd_issue) begin
                r_cnt <= w_cnt_dec;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start_div) begin
            r_work <= DIV_W'(r_accum);
            r_rem  <= '0;
        end else if (i_cmd.div_step) begin
            r_work <= n_work;
            r_rem  <= w_div_last ? '0 : n_rem;
        end
    end

    arc_ram #(
        .WIDTH (DIGIT_W),
        .DEPTH (DEPTH)
    ) u_digits (
        .i_clk   (i_clk),
        .i_we    (i_cmd.div_step && w_div_last),
        .i_waddr (r_cnt[AW-1:0]),
        .i_wdata (n_rem[DIGIT_W-1:0]),
        .i_raddr (w_cnt_dec[AW-1:0]),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_char || i_cmd.load_err) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_char) begin
            r_out_symbol <= r_dst_alpha[SYM_W*int'(w_rdata) +: SYM_W];
            r_out_last   <= (r_cnt == '0);
            r_out_status <= STATUS_OK;
        end else if (i_cmd.load_err) begin
            r_out_symbol <= '0;
            r_out_last   <= 1'b1;
            r_out_status <= r_err;
        end
    end

    assign o_stat.err_set     = (r_err != STATUS_OK);
    assign o_stat.div_last    = w_div_last;
    assign o_stat.digit_final = (n_work == '0) || (r_cnt == CW'(DEPTH - 1));
    assign o_stat.out_free    = w_out_free;
    assign o_stat.cnt_zero    = (r_cnt == '0);

    assign o_out_valid  = r_out_valid;
    assign o_out_symbol = r_out_symbol;
    assign o_out_last   = r_out_last;
    assign o_out_status = r_out_status;

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(DEPTH))
        else $error("digit count beyond store depth");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.load_char || i_cmd.load_err) |-> w_out_free)
        else $error("output register overwritten while stalled");

    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_status != STATUS_OK)) |-> (r_out_last && (r_out_symbol == '0)))
        else $error("error word not a single closing word");

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.accept |-> !(i_cmd.div_step || i_cmd.rd_issue || i_cmd.start_div))
        else $error("input accepted during conversion");

endmodule

`default_nettype wire

// File: rtl/alphabet_radix_converter_core.sv
// ----------------------------------------------------------------------------
// alphabet_radix_converter_core
// Converts a number written in a configured source alphabet into the
// configured destination alphabet, most significant symbol first.
// ----------------------------------------------------------------------------
// Non-last input words are folded into the accumulator (multiply-add) as they are accepted.
// Last word: accepted, then a check state, then the 4-bit-per-cycle divider
// runs per destination digit, then each output word takes a digit RAM read
// and an output register load, waiting while the output register is full.
// An error number gives one output word, loaded from the check state once the output register is free.
// Synchronous active-low reset: radices 10, alphabets 0, no number held.
`default_nettype none

module alphabet_radix_converter_core #(
    parameter int VALUE_BITS = 32
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [arc_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [arc_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_ready,
    input  wire logic [arc_pkg::SYM_W-1:0]       i_in_symbol,
    input  wire logic                            i_in_last,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output logic      [arc_pkg::SYM_W-1:0]       o_out_symbol,
    output logic                                 o_out_last,
    output logic      [1:0]                      o_out_status
);

    import arc_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    arc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_last  (i_in_last),
        .o_in_ready (o_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    arc_dpath #(
        .VALUE_BITS (VALUE_BITS)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_in_symbol  (i_in_symbol),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_symbol (o_out_symbol),
        .o_out_last   (o_out_last),
        .o_out_status (o_out_status)
    );

endmodule

`default_nettype wire
